[hw/rtl/npc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npc_pkg
// Shared constants and types for the nearest palette color block.
// ----------------------------------------------------------------------------
package npc_pkg;

  localparam int DEF_PALETTE_DEPTH = 16;

  localparam int CFG_W     = 5;
  localparam int COLOR_W   = 8;
  localparam int ENTRY_W   = 3 * COLOR_W;
  localparam int IN_IDX_W  = 4;
  localparam int OUT_IDX_W = 4;
  localparam int SQ_W      = 2 * COLOR_W;
  localparam int DIST_W    = 18;
  localparam int DATA_W    = 32;

  localparam logic [DIST_W-1:0] START_BEST_SQ = DIST_W'(67600);
  localparam logic [CFG_W-1:0]  SIZE_RESET    = CFG_W'(1);

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_PIXEL = 1'b1;

  // control that travels alongside one palette read
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    logic cmp_en;
  } npc_tag_t;

endpackage

[hw/rtl/npc_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npc_mem
// Palette store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module npc_mem
  import npc_pkg::*;
#(
  parameter int DEPTH = DEF_PALETTE_DEPTH,
  parameter int AW    = 4
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic [ENTRY_W-1:0] wdata,
  input  logic [AW-1:0]      raddr,
  output logic [ENTRY_W-1:0] rdata
);

  logic [ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/npc_dist.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npc_dist
// Shared distance unit: squared rgb distance of one entry per cycle,
// two register stages.
// ----------------------------------------------------------------------------
module npc_dist
  import npc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  npc_tag_t           tag_in,
  input  logic [ENTRY_W-1:0] entry,
  input  logic [COLOR_W-1:0] pix_red,
  input  logic [COLOR_W-1:0] pix_green,
  input  logic [COLOR_W-1:0] pix_blue,
  output npc_tag_t           tag_out,
  output logic [DIST_W-1:0]  dist_sq,
  output logic [ENTRY_W-1:0] entry_out
);

  function automatic logic [SQ_W-1:0] sq_diff(input logic [COLOR_W-1:0] a,
                                              input logic [COLOR_W-1:0] b);
    logic [COLOR_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return SQ_W'(d) * SQ_W'(d);
  endfunction

  npc_tag_t           tag_a;
  logic [SQ_W-1:0]    sq_r;
  logic [SQ_W-1:0]    sq_g;
  logic [SQ_W-1:0]    sq_b;
  logic [ENTRY_W-1:0] entry_a;

  // stage a: per-channel squares
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_a <= '0;
    end else begin
      tag_a <= tag_in;
    end
  end

  always_ff @(posedge clk) begin
    sq_r    <= sq_diff(pix_red,   entry[3*COLOR_W-1:2*COLOR_W]);
    sq_g    <= sq_diff(pix_green, entry[2*COLOR_W-1:COLOR_W]);
    sq_b    <= sq_diff(pix_blue,  entry[COLOR_W-1:0]);
    entry_a <= entry;
  end

  // stage b: sum
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out <= '0;
    end else begin
      tag_out <= tag_a;
    end
  end

  always_ff @(posedge clk) begin
    dist_sq   <= DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);
    entry_out <= entry_a;
  end

endmodule

[hw/rtl/nearest_palette_color.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_palette_color
// Maps rgb pixels to the nearest loaded palette entry (squared distance,
// ties keep the earlier entry, entry 0 when none is within 260).
// ----------------------------------------------------------------------------
//  channel     | dir | handshake                     | payload
//  s_axis      | in  | s_axis_tvalid / s_axis_tready | tdata index,r,g,b; tuser mode
//  m_axis      | out | m_axis_tvalid / m_axis_tready | tdata r,g,b,index
//  cfg         | in  | cfg_we                        | cfg_wdata palette_size
//
//  a load beat gives no result
//  a pixel scans N entries, N = max(1, min(palette_size, PALETTE_DEPTH)):
//  one palette read per cycle through the single distance unit
//  s_axis_tready is low while a pixel is in work or its result cannot enter
//  the output register; the palette is not cleared by reset
// ----------------------------------------------------------------------------
module nearest_palette_color
  import npc_pkg::*;
#(
  parameter int PALETTE_DEPTH = DEF_PALETTE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  // palette_size
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_wdata,
  // entry_index[3:0], red[11:4], green[19:12], blue[27:20], zero pad
  input  logic [DATA_W-1:0] s_axis_tdata,
  // mode[0]
  input  logic              s_axis_tuser,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // out_red[7:0], out_green[15:8], out_blue[23:16], out_index[27:24], zero pad
  output logic [DATA_W-1:0] m_axis_tdata,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready
);

  localparam int IW   = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int DSW  = $clog2(PALETTE_DEPTH + 1);
  localparam int SW   = (CFG_W > DSW) ? CFG_W : DSW;
  localparam int LW   = (IN_IDX_W > DSW) ? IN_IDX_W : DSW;
  localparam int PADW = DATA_W - 3 * COLOR_W - OUT_IDX_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t             state;
  logic [CFG_W-1:0]   palette_size;
  logic [COLOR_W-1:0] pix_red;
  logic [COLOR_W-1:0] pix_green;
  logic [COLOR_W-1:0] pix_blue;
  logic [IW-1:0]      cnt;
  logic [IW-1:0]      out_cnt;
  logic [IW-1:0]      last_idx;
  logic               cmp_en;
  logic [DIST_W-1:0]  best_sq;
  logic [IW-1:0]      best_idx;
  logic [ENTRY_W-1:0] best_col;
  npc_tag_t           tag_q;
  npc_tag_t           tag_out;
  logic [ENTRY_W-1:0] rd_data;
  logic [DIST_W-1:0]  dist_sq;
  logic [ENTRY_W-1:0] dist_entry;
  logic [SW-1:0]      eff_size;
  logic               accept;
  logic               load_we;
  logic               out_free;

  logic [IN_IDX_W-1:0] in_index;
  logic [COLOR_W-1:0]  in_red;
  logic [COLOR_W-1:0]  in_green;
  logic [COLOR_W-1:0]  in_blue;

  assign in_index = s_axis_tdata[IN_IDX_W-1:0];
  assign in_red   = s_axis_tdata[IN_IDX_W +: COLOR_W];
  assign in_green = s_axis_tdata[IN_IDX_W + COLOR_W +: COLOR_W];
  assign in_blue  = s_axis_tdata[IN_IDX_W + 2*COLOR_W +: COLOR_W];

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign load_we       = accept && (s_axis_tuser == MODE_LOAD)
                         && (LW'(in_index) < LW'(PALETTE_DEPTH));
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // scan length, saturated at the depth; size zero still reads entry 0
  assign eff_size = (SW'(palette_size) > SW'(PALETTE_DEPTH)) ? SW'(PALETTE_DEPTH)
                                                             : SW'(palette_size);
  assign cmp_en   = (eff_size != '0);
  assign last_idx = cmp_en ? IW'(eff_size - SW'(1)) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      palette_size <= SIZE_RESET;
    end else if (cfg_we) begin
      palette_size <= cfg_wdata;
    end
  end

  npc_mem #(
    .DEPTH (PALETTE_DEPTH),
    .AW    (IW)
  ) u_mem (
    .clk   (clk),
    .we    (load_we),
    .waddr (IW'(in_index)),
    .wdata ({in_red, in_green, in_blue}),
    .raddr (cnt),
    .rdata (rd_data)
  );

  // tag lines up with the registered read data
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_q <= '0;
    end else begin
      tag_q.valid  <= (state == S_SCAN);
      tag_q.first  <= (cnt == '0);
      tag_q.last   <= (cnt == last_idx);
      tag_q.cmp_en <= cmp_en;
    end
  end

  npc_dist u_dist (
    .clk       (clk),
    .rst       (rst),
    .tag_in    (tag_q),
    .entry     (rd_data),
    .pix_red   (pix_red),
    .pix_green (pix_green),
    .pix_blue  (pix_blue),
    .tag_out   (tag_out),
    .dist_sq   (dist_sq),
    .entry_out (dist_entry)
  );

  always_ff @(posedge clk) begin
    if (accept && (s_axis_tuser == MODE_PIXEL)) begin
      pix_red   <= in_red;
      pix_green <= in_green;
      pix_blue  <= in_blue;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          cnt <= '0;
          if (accept && (s_axis_tuser == MODE_PIXEL)) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          cnt <= cnt + IW'(1);
          if (cnt == last_idx) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (tag_out.valid && tag_out.last) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // running best
  always_ff @(posedge clk) begin
    if (rst) begin
      best_sq  <= START_BEST_SQ;
      best_idx <= '0;
      out_cnt  <= '0;
    end else if (accept) begin
      best_sq  <= START_BEST_SQ;
      best_idx <= '0;
      out_cnt  <= '0;
    end else if (tag_out.valid) begin
      out_cnt <= out_cnt + IW'(1);
      if (tag_out.cmp_en && (dist_sq < best_sq)) begin
        best_sq  <= dist_sq;
        best_idx <= out_cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tag_out.valid && ((tag_out.cmp_en && (dist_sq < best_sq)) || tag_out.first)) begin
      best_col <= dist_entry;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      m_axis_tdata <= {{PADW{1'b0}}, OUT_IDX_W'(best_idx),
                       best_col[COLOR_W-1:0],
                       best_col[2*COLOR_W-1:COLOR_W],
                       best_col[3*COLOR_W-1:2*COLOR_W]};
    end
  end

  a_best_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> (best_idx <= last_idx))
    else $error("chosen entry lies beyond the scanned range");

  a_best_bounded: assert property (@(posedge clk) disable iff (rst)
    (best_sq <= START_BEST_SQ))
    else $error("best distance above start value");

  a_pipe_in_scan: assert property (@(posedge clk) disable iff (rst)
    tag_out.valid |-> (state == S_SCAN || state == S_DRAIN))
    else $error("distance result outside of a scan");

  a_done_after_last: assert property (@(posedge clk) disable iff (rst)
    $rose(state == S_DONE) |-> $past(tag_out.valid && tag_out.last))
    else $error("scan finished without its last entry");

endmodule
